// ===== rtl/http_response_header_parser_core_macros.svh =====
// Assertion macros shared by the HTTP response header parser RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef HTTP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hrp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hrp assertion failed");

`endif

// ===== rtl/hrp_pkg.sv =====
// Package for the HTTP response header parser: byte codes, phase and event
// encodings, and the result-pair type passed from the engine to the output buffer.
package hrp_pkg;

	localparam int HRP_POSITION_BITS = 32;
	localparam int SKIP_BYTES        = 3;

	localparam logic [7:0] B_CR    = 8'h0D;
	localparam logic [7:0] B_LF    = 8'h0A;
	localparam logic [7:0] B_SP    = 8'h20;
	localparam logic [7:0] B_COLON = 8'h3A;
	localparam logic [7:0] B_ZERO  = 8'h30;
	localparam logic [7:0] B_NINE  = 8'h39;

	// Last three bytes CR LF CR; an LF now completes the header terminator.
	localparam logic [23:0] TERM_PREFIX = 24'h0D0A0D;

	typedef enum logic [3:0] {
		PH_WAIT_SPACE    = 4'd0,
		PH_WAIT_STATUS   = 4'd1,
		PH_STATUS_DIGITS = 4'd2,
		PH_WAIT_LINE_END = 4'd3,
		PH_KEY           = 4'd4,
		PH_KEY_END       = 4'd5,
		PH_VAL           = 4'd6,
		PH_VAL_END       = 4'd7,
		PH_BODY          = 4'd8,
		PH_CLOSED        = 4'd9
	} phase_t;

	typedef enum logic [3:0] {
		EV_NONE       = 4'd0,
		EV_STATUS     = 4'd1,
		EV_KEY_START  = 4'd2,
		EV_KEY_END    = 4'd3,
		EV_VAL_START  = 4'd4,
		EV_VAL_END    = 4'd5,
		EV_HDR_END    = 4'd6,
		EV_BODY       = 4'd7,
		EV_INCOMPLETE = 4'd8
	} event_t;

	// One or two results caused by a single byte; status and count are shared.
	typedef struct packed {
		logic        two;
		event_t      code0;
		logic [31:0] pos0;
		event_t      code1;
		logic [31:0] pos1;
		logic [15:0] status;
		logic [15:0] hdr_cnt;
	} pair_t;

endpackage

// ===== rtl/hrp_byte_if.sv =====
// Input channel of the HTTP response header parser: one response byte per beat.
// Depends on nothing.
interface hrp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_response;
	logic       end_of_stream;

	modport source (output valid, data_byte, first_of_response, end_of_stream, input ready);
	modport sink (input valid, data_byte, first_of_response, end_of_stream, output ready);
endinterface

// ===== rtl/hrp_result_if.sv =====
// Output channel of the HTTP response header parser: one parse event per beat.
// Depends on nothing.
interface hrp_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_res;
	logic [31:0] position;
	logic [15:0] status_value;
	logic [15:0] header_count;
	logic        last_of_run;

	modport source (output valid, event_res, position, status_value, header_count,
		last_of_run, input ready);
	modport sink (input valid, event_res, position, status_value, header_count,
		last_of_run, output ready);
endinterface

// ===== rtl/http_response_header_parser_core.sv =====
// HTTP response header parser: one byte per beat in, one parse event per beat out.
// A byte passes through the input register and then the result buffer register before its first result is offered.
// Throughput: one byte per cycle while result_ch.ready is high; a byte that raises two events
// holds its slot in the output register until both are taken, which holds back the input.
// Reset (arst_n low, asynchronous) clears the parse state, offsets and all valids.
// Depends on hrp_pkg, hrp_byte_if, hrp_result_if, hrp_engine and hrp_result_buf.
module http_response_header_parser_core import hrp_pkg::*; #(
	parameter int POSITION_BITS = HRP_POSITION_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	hrp_byte_if.sink      data_ch,
	hrp_result_if.source  result_ch
);

	// The design is three short stages. An input register takes each accepted
	// beat. The engine then evaluates that byte against the parser state in one
	// pass and commits the state update in the same cycle that its one or two
	// events are written into the result buffer. The buffer presents the events
	// one beat at a time, with last_of_run on the final one of the byte.

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       eos_s1;
	logic       can_load;
	logic       go;
	logic       accept;
	pair_t      pair;

	// The input register moves on when the result buffer can take the events of
	// the byte it holds, so while results still wait a new byte is taken only into an empty input register.
	assign go            = v_s1 && can_load;
	assign data_ch.ready = !v_s1 || can_load;
	assign accept        = data_ch.valid && data_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (go) begin
			v_s1 <= 1'b0;
		end
	end

	// The payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= data_ch.data_byte;
			first_s1 <= data_ch.first_of_response;
			eos_s1   <= data_ch.end_of_stream;
		end
	end

	hrp_engine #(
		.POSITION_BITS(POSITION_BITS)
	) u_engine (
		.clk               (clk),
		.arst_n            (arst_n),
		.go                (go),
		.data_byte         (byte_s1),
		.first_of_response (first_s1),
		.end_of_stream     (eos_s1),
		.pair              (pair)
	);

	hrp_result_buf u_result_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (go),
		.pair     (pair),
		.can_load (can_load),
		.res      (result_ch)
	);

endmodule

// ===== rtl/hrp_engine.sv =====
// Parse engine: holds the parser state and turns one registered byte into one
// or two events. Depends on hrp_pkg and the assertion macro header.
`include "http_response_header_parser_core_macros.svh"

module hrp_engine import hrp_pkg::*; #(
	parameter int POSITION_BITS = HRP_POSITION_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] data_byte,
	input  logic       first_of_response,
	input  logic       end_of_stream,
	output pair_t      pair
);

	localparam int PW = (POSITION_BITS < 32) ? POSITION_BITS : 32;

	phase_t                   phase_q, ph_c, ph_n, ph_eff;
	logic [23:0]              prior_q, prior_c;
	logic [POSITION_BITS-1:0] off_q, off_c, pos_p1, pos_m1, p_pos;
	logic [15:0]              acc_q, acc_c, acc_n;
	logic                     held_q, held_c, held_n;
	logic [15:0]              pairs_q, pairs_c, pairs_n;
	logic                     digit, after_cr, window, past_skip;
	logic [19:0]              mul10;
	logic                     p_has;
	event_t                   p_code;

	always_comb begin
		ph_c    = first_of_response ? PH_WAIT_SPACE : phase_q;
		prior_c = first_of_response ? 24'd0 : prior_q;
		off_c   = first_of_response ? '0 : off_q;
		acc_c   = first_of_response ? 16'd0 : acc_q;
		held_c  = first_of_response ? 1'b0 : held_q;
		pairs_c = first_of_response ? 16'd0 : pairs_q;
	end

	assign digit     = data_byte inside {[B_ZERO:B_NINE]};
	assign after_cr  = (prior_c[7:0] == B_CR);
	assign past_skip = (off_c >= POSITION_BITS'(SKIP_BYTES));
	assign window    = past_skip && (prior_c == TERM_PREFIX) && (data_byte == B_LF);
	assign pos_p1    = off_c + POSITION_BITS'(1);
	assign pos_m1    = off_c - POSITION_BITS'(1);
	assign mul10     = ({4'd0, acc_c} << 3) + ({4'd0, acc_c} << 1)
		+ 20'(data_byte - B_ZERO);

	always_comb begin
		ph_n    = ph_c;
		acc_n   = acc_c;
		held_n  = held_c;
		pairs_n = pairs_c;
		ph_eff  = ph_c;
		p_has   = 1'b0;
		p_code  = EV_NONE;
		p_pos   = off_c;
		pair.two     = 1'b0;
		pair.code0   = EV_NONE;
		pair.pos0    = 32'(off_c[PW-1:0]);
		pair.code1   = EV_NONE;
		pair.pos1    = 32'(off_c[PW-1:0]);

		if (ph_c == PH_BODY) begin
			pair.code0 = EV_BODY;
		end else if (ph_c == PH_CLOSED) begin
			pair.code0 = EV_NONE;
		end else if (window) begin
			pair.code0 = EV_HDR_END;
			pair.pos0  = 32'(pos_p1[PW-1:0]);
			ph_n       = PH_BODY;
			held_n     = 1'b0;
		end else if (end_of_stream) begin
			pair.code0 = EV_INCOMPLETE;
			ph_n       = PH_CLOSED;
			held_n     = 1'b0;
		end else if (past_skip) begin
			// A held CR that did not finish the terminator starts a key.
			if (held_c) begin
				held_n = 1'b0;
				ph_eff = PH_KEY_END;
			end
			ph_n = ph_eff;
			case (ph_eff)
				PH_WAIT_SPACE: begin
					if (data_byte == B_SP) ph_n = PH_WAIT_STATUS;
				end
				PH_WAIT_STATUS: begin
					if (data_byte != B_SP) begin
						if (digit) begin
							acc_n = 16'(data_byte - B_ZERO);
							ph_n  = PH_STATUS_DIGITS;
						end else begin
							acc_n  = 16'd0;
							p_has  = 1'b1;
							p_code = EV_STATUS;
							ph_n   = PH_WAIT_LINE_END;
						end
					end
				end
				PH_STATUS_DIGITS: begin
					if (digit) begin
						acc_n = (mul10 > 20'd65535) ? 16'hFFFF : mul10[15:0];
					end else begin
						p_has  = 1'b1;
						p_code = EV_STATUS;
						ph_n   = PH_WAIT_LINE_END;
					end
				end
				PH_WAIT_LINE_END: begin
					if (data_byte == B_LF && after_cr) ph_n = PH_KEY;
				end
				PH_KEY: begin
					if (data_byte == B_CR) begin
						held_n = 1'b1;
					end else if (data_byte != B_SP) begin
						p_has  = 1'b1;
						p_code = EV_KEY_START;
						ph_n   = PH_KEY_END;
					end
				end
				PH_KEY_END: begin
					if (data_byte == B_COLON) begin
						p_has  = 1'b1;
						p_code = EV_KEY_END;
						ph_n   = PH_VAL;
					end
				end
				PH_VAL: begin
					if (data_byte != B_SP) begin
						p_has  = 1'b1;
						p_code = EV_VAL_START;
						ph_n   = PH_VAL_END;
					end
				end
				PH_VAL_END: begin
					if (data_byte == B_LF && after_cr) begin
						p_has  = 1'b1;
						p_code = EV_VAL_END;
						p_pos  = pos_m1;
						ph_n   = PH_KEY;
						if (pairs_c != 16'hFFFF) pairs_n = pairs_c + 16'd1;
					end
				end
				default: begin
					ph_n = ph_eff;
				end
			endcase

			if (held_c) begin
				pair.code0 = EV_KEY_START;
				pair.pos0  = 32'(pos_m1[PW-1:0]);
				pair.two   = p_has;
				pair.code1 = p_code;
				pair.pos1  = 32'(p_pos[PW-1:0]);
			end else if (p_has) begin
				pair.code0 = p_code;
				pair.pos0  = 32'(p_pos[PW-1:0]);
			end
		end

		pair.status  = acc_n;
		pair.hdr_cnt = pairs_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_SPACE;
			prior_q <= 24'd0;
			off_q   <= '0;
			acc_q   <= 16'd0;
			held_q  <= 1'b0;
			pairs_q <= 16'd0;
		end else if (go) begin
			phase_q <= ph_n;
			prior_q <= {prior_c[15:0], data_byte};
			off_q   <= pos_p1;
			acc_q   <= acc_n;
			held_q  <= held_n;
			pairs_q <= pairs_n;
		end
	end

	`HRP_ASSERT_NOW(a_held_only_in_key, clk, arst_n, held_q, phase_q == PH_KEY)
	`HRP_ASSERT_NEXT(a_body_sticks, clk, arst_n,
		go && phase_q == PH_BODY && !first_of_response, phase_q == PH_BODY)
	`HRP_ASSERT_NOW(a_pair_has_first, clk, arst_n, go && pair.two, pair.code0 == EV_KEY_START)

endmodule

// ===== rtl/hrp_result_buf.sv =====
// Result buffer: registers the one or two events of a byte and hands them out
// one beat at a time. Depends on hrp_pkg, hrp_result_if and the macro header.
`include "http_response_header_parser_core_macros.svh"

module hrp_result_buf import hrp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  pair_t           pair,
	output logic            can_load,
	hrp_result_if.source    res
);

	logic  v_q;
	logic  idx_q;
	pair_t pair_q;
	logic  last;
	logic  fire;

	assign last     = idx_q || !pair_q.two;
	assign fire     = v_q && res.ready;
	assign can_load = !v_q || (res.ready && last);

	assign res.valid        = v_q;
	assign res.event_res    = idx_q ? pair_q.code1 : pair_q.code0;
	assign res.position     = idx_q ? pair_q.pos1 : pair_q.pos0;
	assign res.status_value = pair_q.status;
	assign res.header_count = pair_q.hdr_cnt;
	assign res.last_of_run  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= 1'b0;
			idx_q <= 1'b0;
		end else if (load) begin
			v_q   <= 1'b1;
			idx_q <= 1'b0;
		end else if (fire) begin
			if (last) begin
				v_q   <= 1'b0;
				idx_q <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) pair_q <= pair;
	end

	`HRP_ASSERT_NEXT(a_second_follows, clk, arst_n, fire && !last, v_q && idx_q && last)
	`HRP_ASSERT_NOW(a_idx_needs_pair, clk, arst_n, v_q && idx_q, pair_q.two)
	`HRP_ASSERT_NOW(a_idle_idx_clear, clk, arst_n, !v_q, !idx_q)

endmodule
